// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the WAV parser.
// Depends on nothing; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/wpp_pkg.sv =====
// Shared types, tags and codes for the RIFF/WAVE PCM stream parser.
// Depends on nothing.
`default_nettype none
package wpp_pkg;

    localparam int M_TDATA_W = 104;

    localparam logic [31:0] RIFF_TAG = 32'h5249_4646;
    localparam logic [31:0] WAVE_TAG = 32'h5741_5645;
    localparam logic [31:0] FMT_TAG  = 32'h666D_7420;
    localparam logic [31:0] DATA_TAG = 32'h6461_7461;
    localparam logic [31:0] SAT_MAX  = 32'hFFFF_FFFF;
    localparam logic [7:0]  OFFSET_FLIP = 8'h80;

    typedef enum logic [3:0] {
        PH_RIFF    = 4'd0,
        PH_SIZE    = 4'd1,
        PH_WAVE    = 4'd2,
        PH_HDR     = 4'd3,
        PH_FMT     = 4'd4,
        PH_DATA    = 4'd5,
        PH_SKIP    = 4'd6,
        PH_PAD     = 4'd7,
        PH_ENDPEND = 4'd8,
        PH_HALT    = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FORMAT = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_EOF    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD_RIFF   = 3'd1,
        ERR_BAD_WAVE   = 3'd2,
        ERR_BAD_BITS   = 3'd3,
        ERR_DATA_FIRST = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        err_t        err;
    } res_t;

    // Byte idx of a four-character tag, first character at idx 0.
    function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
        return tag[{~idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== sv/wpp_in_stage.sv =====
// Input register of the WAV parser: holds one byte beat until the parser takes it.
// Depends on wpp_pkg.
`default_nettype none
module wpp_in_stage
    import wpp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     advance,
    output logic          item_valid,
    output in_item_t      item
);

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    // Refill in the same cycle the held beat is consumed.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ===== sv/wpp_parser.sv =====
// Parse state of the WAV parser and the per-byte field logic.
// Depends on wpp_pkg.
`default_nettype none
module wpp_parser
    import wpp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_item_t item,
    output logic          produced,
    output res_t          res
);

    phase_t      ph_reg, ph_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] riff_reg, riff_next;
    logic [31:0] bc_reg, bc_next;
    logic [15:0] fch_reg, fch_next;
    logic [31:0] frate_reg, frate_next;
    logic [15:0] fbits_reg, fbits_next;
    logic        fseen_reg, fseen_next;
    logic [31:0] asm_reg, asm_next;

    always_comb begin
        phase_t      ph;
        logic [31:0] cnt, tag, rem, riff, bc, frate, asm_cur, asm_base, bc_inc;
        logic [15:0] fch, fbits;
        logic        fseen, room, go_end, go_bnd, halted, bps8, mono;
        logic [1:0]  mask, pos;
        logic [7:0]  b;

        b = item.data;
        // A start beat parses from the reset state.
        if (item.start) begin
            ph = PH_RIFF; cnt = '0; tag = '0; rem = '0; riff = '0; bc = '0;
            fch = '0; frate = '0; fbits = '0; fseen = 1'b0; asm_cur = '0;
        end else begin
            ph = ph_reg; cnt = cnt_reg; tag = tag_reg; rem = rem_reg; riff = riff_reg;
            bc = bc_reg; fch = fch_reg; frate = frate_reg; fbits = fbits_reg;
            fseen = fseen_reg; asm_cur = asm_reg;
        end

        ph_next = ph; cnt_next = cnt; tag_next = tag; rem_next = rem; riff_next = riff;
        bc_next = bc; fch_next = fch; frate_next = frate; fbits_next = fbits;
        fseen_next = fseen; asm_next = asm_cur;
        produced = 1'b0;
        res      = '0;
        go_end   = 1'b0;
        go_bnd   = 1'b0;
        halted   = 1'b0;

        bc_inc = (bc == SAT_MAX) ? bc : bc + 32'd1;
        // Room for another chunk header once this byte is counted.
        room = (bc != SAT_MAX) && (({1'b0, bc} + 33'd9) <= {1'b0, riff});

        bps8     = (fbits == 16'd8);
        mono     = (fch == 16'd1);
        mask     = {!bps8 && !mono, !(bps8 && mono)};
        pos      = cnt[1:0] & mask;
        asm_base = (pos == 2'd0) ? 32'd0 : asm_cur;

        case (ph)
            PH_RIFF: begin
                if (b != tag_byte(RIFF_TAG, cnt[1:0])) begin
                    ph_next  = PH_HALT;
                    produced = 1'b1;
                    res.kind = KIND_ERROR;
                    res.err  = ERR_BAD_RIFF;
                end else if (cnt == 32'd3) begin
                    ph_next  = PH_SIZE;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt + 32'd1;
                end
            end
            PH_SIZE: begin
                riff_next[{cnt[1:0], 3'b000} +: 8] = b;
                if (cnt == 32'd3) begin
                    ph_next  = PH_WAVE;
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt + 32'd1;
                end
            end
            PH_WAVE: begin
                bc_next = bc_inc;
                if (b != tag_byte(WAVE_TAG, cnt[1:0])) begin
                    ph_next  = PH_HALT;
                    produced = 1'b1;
                    res.kind = KIND_ERROR;
                    res.err  = ERR_BAD_WAVE;
                end else begin
                    cnt_next = cnt + 32'd1;
                    go_bnd   = (cnt == 32'd3);
                end
            end
            PH_HDR: begin
                bc_next = bc_inc;
                if (cnt < 32'd4) begin
                    tag_next = {tag[23:0], b};
                end else begin
                    rem_next[{cnt[1:0], 3'b000} +: 8] = b;
                end
                cnt_next = cnt + 32'd1;
                if (cnt == 32'd7) begin
                    cnt_next = '0;
                    asm_next = '0;
                    if (tag_next == FMT_TAG) begin
                        ph_next    = PH_FMT;
                        fch_next   = '0;
                        frate_next = '0;
                        fbits_next = '0;
                    end else if (tag_next == DATA_TAG) begin
                        if (!fseen) begin
                            ph_next  = PH_HALT;
                            halted   = 1'b1;
                            produced = 1'b1;
                            res.kind = KIND_ERROR;
                            res.err  = ERR_DATA_FIRST;
                        end else begin
                            ph_next = PH_DATA;
                        end
                    end else begin
                        ph_next = PH_SKIP;
                    end
                    go_end = !halted && (rem_next == 32'd0);
                end
            end
            PH_FMT, PH_DATA, PH_SKIP: begin
                bc_next = bc_inc;
                if (ph == PH_FMT) begin
                    if (cnt == 32'd2 || cnt == 32'd3) begin
                        fch_next[{cnt[0], 3'b000} +: 8] = b;
                    end else if (cnt >= 32'd4 && cnt <= 32'd7) begin
                        frate_next[{cnt[1:0], 3'b000} +: 8] = b;
                    end else if (cnt == 32'd14 || cnt == 32'd15) begin
                        fbits_next[{cnt[0], 3'b000} +: 8] = b;
                    end
                end else if (ph == PH_DATA) begin
                    asm_next = asm_base | ({24'd0, b} << {pos, 3'b000});
                    if (pos == mask) begin
                        produced = 1'b1;
                        res.kind = KIND_SAMPLE;
                        if (bps8) begin
                            res.left  = {asm_next[7:0] ^ OFFSET_FLIP, 8'h00};
                            res.right = mono ? res.left
                                             : {asm_next[15:8] ^ OFFSET_FLIP, 8'h00};
                        end else begin
                            res.left  = asm_next[15:0];
                            res.right = mono ? asm_next[15:0] : asm_next[31:16];
                        end
                    end
                end
                cnt_next = cnt + 32'd1;
                rem_next = rem - 32'd1;
                go_end   = (rem == 32'd1);
            end
            PH_PAD: begin
                bc_next = bc_inc;
                go_bnd  = 1'b1;
            end
            PH_ENDPEND: begin
                ph_next  = PH_HALT;
                produced = 1'b1;
                res.kind = KIND_EOF;
            end
            default: begin
            end
        endcase

        // Body end: format or bits error; if live, pad or move on.
        if (go_end) begin
            if (ph_next == PH_FMT) begin
                produced = 1'b1;
                if (fbits_next != 16'd8 && fbits_next != 16'd16) begin
                    ph_next  = PH_HALT;
                    halted   = 1'b1;
                    res.kind = KIND_ERROR;
                    res.err  = ERR_BAD_BITS;
                end else begin
                    fseen_next   = 1'b1;
                    res.kind     = KIND_FORMAT;
                    res.channels = fch_next;
                    res.rate     = frate_next;
                    res.bits     = fbits_next;
                end
            end
            if (!halted) begin
                if (cnt_next[0]) begin
                    ph_next = PH_PAD;
                end else begin
                    go_bnd = 1'b1;
                end
            end
        end

        if (go_bnd) begin
            if (room) begin
                ph_next  = PH_HDR;
                cnt_next = '0;
                tag_next = '0;
                rem_next = '0;
            end else if (produced) begin
                // Hold the end-of-file beat for the next byte.
                ph_next = PH_ENDPEND;
            end else begin
                ph_next  = PH_HALT;
                produced = 1'b1;
                res.kind = KIND_EOF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg    <= PH_RIFF;
            cnt_reg   <= '0;
            tag_reg   <= '0;
            rem_reg   <= '0;
            riff_reg  <= '0;
            bc_reg    <= '0;
            fch_reg   <= '0;
            frate_reg <= '0;
            fbits_reg <= '0;
            fseen_reg <= 1'b0;
            asm_reg   <= '0;
        end else if (advance) begin
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
            tag_reg   <= tag_next;
            rem_reg   <= rem_next;
            riff_reg  <= riff_next;
            bc_reg    <= bc_next;
            fch_reg   <= fch_next;
            frate_reg <= frate_next;
            fbits_reg <= fbits_next;
            fseen_reg <= fseen_next;
            asm_reg   <= asm_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/wpp_out_stage.sv =====
// Result register of the WAV parser: holds one result beat until the sink takes it.
// Depends on wpp_pkg.
`default_nettype none
module wpp_out_stage
    import wpp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire logic                 produced,
    input  wire res_t                 res,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                m_tuser
);

    logic valid_reg, valid_next;
    res_t res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = produced;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produced) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {5'd0, res_reg.err, res_reg.bits, res_reg.rate, res_reg.channels,
                       res_reg.right, res_reg.left};

endmodule
`default_nettype wire

// ===== sv/wave_pcm_stream_parser_top.sv =====
// RIFF/WAVE PCM stream parser, one file byte per input beat.
// Path: each byte beat is registered in the input register, and the result beat it causes in the result register.
// Throughput: one byte per cycle, set by the single-pass field logic between the
// input register and the result register; a stalled sink holds both stages.
// Reset: synchronous, active low; clears both stages and returns the parse to the RIFF tag.
`default_nettype none
module wave_pcm_stream_parser_top
    import wpp_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] in_byte
    input  wire logic                 s_tuser,   // [0] start_req
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [15:0] left_sample, [31:16] right_sample, [47:32] channel_count,
    // [79:48] sample_rate, [95:80] sample_bits, [98:96] error_code, [103:99] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                m_tuser    // [1:0] kind
);

    in_item_t s_item, item;
    logic     item_valid, advance, produced;
    res_t     res;

    assign s_item.data  = s_tdata;
    assign s_item.start = s_tuser;

    // Advance when a byte is held and the result register is free or draining.
    assign advance = item_valid && (!m_tvalid || m_tready);

    wpp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wpp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (item),
        .produced (produced),
        .res      (res)
    );

    wpp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .produced (produced),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== sv/wpp_checker.sv =====
// Port-level checks for the WAV parser top level, bound to it below.
// Depends on wpp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wpp_checker
    import wpp_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]           m_tuser
);

    `ASSERT_CLK(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
    `ASSERT_CLK_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_sample_clean, aclk, aresetn, m_tvalid && m_tuser == KIND_SAMPLE |-> m_tdata[M_TDATA_W-1:32] == '0, "sample beat carries format or error bits")
    `ASSERT_CLK(a_error_code, aclk, aresetn, m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[98:96] != ERR_NONE && m_tdata[98:96] <= ERR_DATA_FIRST && m_tdata[95:0] == '0, "bad error beat")
    `ASSERT_CLK(a_format_bits, aclk, aresetn, m_tvalid && m_tuser == KIND_FORMAT |-> m_tdata[95:80] == 16'd8 || m_tdata[95:80] == 16'd16, "format beat with unsupported bits")

endmodule

bind wave_pcm_stream_parser_top wpp_checker u_wpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/wave_pcm_stream_parser_top_test.sv =====
// Self-checking bench for wave_pcm_stream_parser_top: byte beats of built and broken WAV files
// go in, each result beat is compared with a cycle-free model of the parse held in a class.
// Depends on wpp_pkg and the top level; needs no files or arguments.
module wave_pcm_stream_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wpp_pkg::*;

    localparam int ITEMS        = 1400;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        SC_GOOD, SC_BAD_RIFF, SC_BAD_WAVE, SC_DATA_FIRST, SC_BAD_BITS,
        SC_SHORT_FMT, SC_LONG_RIFF, SC_SHORT_RIFF, SC_TRUNCATED, SC_NOISE, SC_COUNT
    } scen_t;

    // Parse model and result store; tracks the block's state byte by byte.
    class wav_checker;
        phase_t      ph;
        logic [31:0] idx, tag, remain, riff_len, consumed, rate, assembly;
        logic [15:0] chans, bits;
        bit          fmt_ok;
        res_t        results_due[$];
        int          errors;
        int          seen[4];

        function new();
            clear_state();
        endfunction

        function void clear_state();
            ph = PH_RIFF;
            idx = '0; tag = '0; remain = '0; riff_len = '0; consumed = '0;
            rate = '0; assembly = '0; chans = '0; bits = '0;
            fmt_ok = 1'b0;
        endfunction

        function int due();
            return results_due.size();
        endfunction

        function void emit(kind_t k, logic [15:0] l, logic [15:0] r, logic [15:0] ch,
                           logic [31:0] rt, logic [15:0] bt, err_t e);
            res_t x;
            x.kind = k; x.left = l; x.right = r; x.channels = ch;
            x.rate = rt; x.bits = bt; x.err = e;
            results_due.push_back(x);
        endfunction

        function void bump();
            if (consumed != SAT_MAX)
                consumed++;
        endfunction

        // Chunk boundary: open another header or close the file.
        function bit at_boundary(bit produced);
            if ({1'b0, consumed} + 33'd8 <= {1'b0, riff_len}) begin
                ph = PH_HDR;
                idx = '0; tag = '0; remain = '0;
                return produced;
            end
            if (produced) begin
                ph = PH_ENDPEND;
                return 1'b1;
            end
            ph = PH_HALT;
            emit(KIND_EOF, 0, 0, 0, 0, 0, ERR_NONE);
            return 1'b1;
        endfunction

        function bit chunk_end(bit produced);
            if (ph == PH_FMT) begin
                if (bits != 16'd8 && bits != 16'd16) begin
                    ph = PH_HALT;
                    emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_BAD_BITS);
                    return 1'b1;
                end
                fmt_ok = 1'b1;
                emit(KIND_FORMAT, 0, 0, chans, rate, bits, ERR_NONE);
                produced = 1'b1;
            end
            if (idx[0]) begin
                ph = PH_PAD;
                return produced;
            end
            return at_boundary(produced);
        endfunction

        // Returns 1 when the byte reaches a live parse rather than a halted one.
        function bit note_byte(logic [7:0] b, logic st);
            bit          live;
            bit          produced;
            int          sh;
            int unsigned bps, fsize, pos;
            logic [15:0] l, r;
            if (st)
                clear_state();
            live = (ph != PH_HALT);
            produced = 1'b0;
            sh = 8 * (3 - int'(idx[1:0]));
            case (ph)
                PH_RIFF: begin
                    if (b != 8'(RIFF_TAG >> sh)) begin
                        ph = PH_HALT;
                        emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_BAD_RIFF);
                    end else begin
                        idx++;
                        if (idx == 4) begin
                            ph = PH_SIZE;
                            idx = '0;
                        end
                    end
                end
                PH_SIZE: begin
                    riff_len |= 32'(b) << (8 * idx[1:0]);
                    idx++;
                    if (idx == 4) begin
                        ph = PH_WAVE;
                        idx = '0;
                    end
                end
                PH_WAVE: begin
                    bump();
                    if (b != 8'(WAVE_TAG >> sh)) begin
                        ph = PH_HALT;
                        emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_BAD_WAVE);
                    end else begin
                        idx++;
                        if (idx == 4)
                            void'(at_boundary(1'b0));
                    end
                end
                PH_HDR: begin
                    bump();
                    if (idx < 4)
                        tag = {tag[23:0], b};
                    else
                        remain |= 32'(b) << (8 * idx[1:0]);
                    idx++;
                    if (idx == 8) begin
                        idx = '0;
                        assembly = '0;
                        if (tag == FMT_TAG) begin
                            ph = PH_FMT;
                            chans = '0; rate = '0; bits = '0;
                        end else if (tag == DATA_TAG) begin
                            if (!fmt_ok) begin
                                ph = PH_HALT;
                                emit(KIND_ERROR, 0, 0, 0, 0, 0, ERR_DATA_FIRST);
                                return live;
                            end
                            ph = PH_DATA;
                        end else begin
                            ph = PH_SKIP;
                        end
                        if (remain == 0)
                            void'(chunk_end(1'b0));
                    end
                end
                PH_FMT, PH_DATA, PH_SKIP: begin
                    bump();
                    if (ph == PH_FMT) begin
                        if (idx == 2 || idx == 3)
                            chans |= 16'(b) << (8 * (idx - 2));
                        else if (idx >= 4 && idx <= 7)
                            rate |= 32'(b) << (8 * (idx - 4));
                        else if (idx == 14 || idx == 15)
                            bits |= 16'(b) << (8 * (idx - 14));
                    end else if (ph == PH_DATA) begin
                        bps = (bits == 16'd8) ? 1 : 2;
                        fsize = bps * ((chans == 16'd1) ? 1 : 2);
                        pos = idx & (fsize - 1);
                        if (pos == 0)
                            assembly = '0;
                        assembly |= 32'(b) << (8 * pos);
                        if (pos == fsize - 1) begin
                            if (bps == 1) begin
                                l = {assembly[7:0] ^ OFFSET_FLIP, 8'h00};
                                r = (fsize == 1) ? l : {assembly[15:8] ^ OFFSET_FLIP, 8'h00};
                            end else begin
                                l = assembly[15:0];
                                r = (fsize == 2) ? l : assembly[31:16];
                            end
                            emit(KIND_SAMPLE, l, r, 0, 0, 0, ERR_NONE);
                            produced = 1'b1;
                        end
                    end
                    idx++;
                    remain--;
                    if (remain == 0)
                        void'(chunk_end(produced));
                end
                PH_PAD: begin
                    bump();
                    void'(at_boundary(1'b0));
                end
                PH_ENDPEND: begin
                    ph = PH_HALT;
                    emit(KIND_EOF, 0, 0, 0, 0, 0, ERR_NONE);
                end
                default: ;
            endcase
            return live;
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic [1:0] k, logic [M_TDATA_W-1:0] d);
            res_t e;
            if (results_due.size() == 0) begin
                $display("%0t: result beat with none due, kind %0d, tdata 0x%0h", $time, k, d);
                errors++;
                return;
            end
            e = results_due.pop_front();
            compare("kind", e.kind, k);
            compare("left_sample", e.left, d[15:0]);
            compare("right_sample", e.right, d[31:16]);
            compare("channel_count", e.channels, d[47:32]);
            compare("sample_rate", e.rate, d[79:48]);
            compare("sample_bits", e.bits, d[95:80]);
            compare("error_code", e.err, d[98:96]);
            compare("tdata fill", 0, d[103:99]);
            if (!$isunknown(k))
                seen[k]++;
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;

    wav_checker  sb;
    logic [7:0]  wav_bytes[$];
    int unsigned burst_left;
    int unsigned parsed_beats;
    int unsigned byte_beats;
    int unsigned stall_cycles;
    int unsigned rx_tick;
    int unsigned rx_mode;
    int unsigned hold_left;
    bit          hold_req;

    wave_pcm_stream_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: changes its stall pattern every so often; long hold-off on request.
    initial begin
        m_tready = 1'b0;
        rx_tick = 0;
        rx_mode = 0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            rx_tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (rx_tick % 97 == 0)
                    rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (rx_tick % 5 < 2);
                endcase
            end
        end
    end

    // Sample both channels at the rising edge; results first, then the byte beat.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_beat(m_tuser, m_tdata);
            if (s_tvalid && s_tready) begin
                byte_beats++;
                if (sb.note_byte(s_tdata, s_tuser))
                    parsed_beats++;
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, sb.due());
        $display("FAIL");
        $finish;
    end

    // Called at a falling edge; returns at a falling edge with the beat taken.
    task automatic offer_beat(logic [7:0] b, bit st);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_wav();
        foreach (wav_bytes[i])
            offer_beat(wav_bytes[i], i == 0);
    endtask

    function automatic logic [7:0] sample_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 12);
        repeat (n)
            offer_beat(sample_byte(), $urandom_range(0, 3) == 0);
    endtask

    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            wav_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            wav_bytes.push_back(t[8*i +: 8]);
    endfunction

    // Body of random bytes plus the pad byte that an odd size needs.
    function automatic void put_body(int unsigned size);
        repeat (size)
            wav_bytes.push_back(sample_byte());
        if (size[0])
            wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_skip();
        int unsigned size;
        logic [31:0] t;
        size = $urandom_range(0, 9);
        case ($urandom_range(0, 2))
            0: t = 32'h4C49_5354;
            1: t = 32'h6A75_6E6B;
            default: t = $urandom;
        endcase
        put_tag(t);
        put_le(size, 4);
        put_body(size);
    endfunction

    function automatic void put_data(int unsigned size);
        put_tag(DATA_TAG);
        put_le(size, 4);
        put_body(size);
    endfunction

    function automatic void put_fmt(logic [15:0] ch, logic [31:0] rt, logic [15:0] bt,
                                    int unsigned size);
        logic [7:0] hdr[16];
        hdr = '{8'h01, 8'h00, ch[7:0], ch[15:8], rt[7:0], rt[15:8], rt[23:16], rt[31:24],
                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom), bt[7:0], bt[15:8]};
        put_tag(FMT_TAG);
        put_le(size, 4);
        for (int unsigned i = 0; i < size; i++)
            wav_bytes.push_back(i < 16 ? hdr[i] : 8'($urandom));
        if (size[0])
            wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] pick_channels();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'd1;
            4, 5, 6, 7: return 16'd2;
            8: return $urandom_range(0, 1) ? 16'd0 : 16'd3;
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'd44100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_bad_bits();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'd24;
            2: return 16'd32;
            3: return 16'hFFFF;
            default: begin
                do v = 16'($urandom); while (v == 16'd8 || v == 16'd16);
                return v;
            end
        endcase
    endfunction

    function automatic int unsigned pick_fmt_size();
        case ($urandom_range(0, 5))
            0: return 18;
            1: return 17;
            2: return $urandom_range(19, 24);
            default: return 16;
        endcase
    endfunction

    // Fill wav_bytes with one file of the given flavour.
    function automatic void build_wav(scen_t sc);
        logic [15:0] ch, bt;
        logic [31:0] rt, len;
        int unsigned frame, n, p, fsz;
        wav_bytes.delete();
        ch = pick_channels();
        rt = pick_rate();
        bt = $urandom_range(0, 1) ? 16'd8 : 16'd16;
        if (sc == SC_BAD_BITS)
            bt = pick_bad_bits();
        frame = ((bt == 16'd8) ? 1 : 2) * ((ch == 16'd1) ? 1 : 2);
        put_tag(RIFF_TAG);
        put_le(32'h0, 4);
        put_tag(WAVE_TAG);
        case (sc)
            SC_BAD_RIFF: begin
                p = $urandom_range(0, 3);
                wav_bytes[p] = wav_bytes[p] ^ 8'($urandom_range(1, 255));
            end
            SC_BAD_WAVE: begin
                p = $urandom_range(8, 11);
                wav_bytes[p] = wav_bytes[p] ^ 8'($urandom_range(1, 255));
            end
            SC_DATA_FIRST: begin
                if ($urandom_range(0, 1))
                    put_skip();
                put_data($urandom_range(0, 6));
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    put_skip();
                fsz = (sc == SC_SHORT_FMT) ? $urandom_range(0, 15) : pick_fmt_size();
                put_fmt(ch, rt, bt, fsz);
                if ($urandom_range(0, 3) == 0)
                    put_skip();
                n = frame * $urandom_range(0, 6);
                if ($urandom_range(0, 2) == 0)
                    n += $urandom % frame;
                put_data(n);
                if ($urandom_range(0, 4) == 0)
                    put_data(frame * $urandom_range(0, 3));
                if ($urandom_range(0, 3) == 0)
                    put_skip();
            end
        endcase
        len = wav_bytes.size() - 8;
        case (sc)
            SC_LONG_RIFF: len = $urandom_range(0, 1) ? SAT_MAX : len + 8 + $urandom_range(0, 64);
            SC_SHORT_RIFF: len = len - $urandom_range(1, len);
            SC_GOOD: if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 7);
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
            wav_bytes[4 + i] = len[8*i +: 8];
        if (sc == SC_TRUNCATED) begin
            n = $urandom_range(1, wav_bytes.size() - 1);
            while (wav_bytes.size() > n)
                void'(wav_bytes.pop_back());
        end else begin
            // trailing bytes let a pending end of file come out
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 2);
            repeat (n)
                wav_bytes.push_back(8'($urandom));
        end
    endfunction

    initial begin
        scen_t       sc;
        int unsigned files, holds, next_hold, r;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        hold_req = 1'b0;
        burst_left = 0;
        parsed_beats = 0;
        byte_beats = 0;
        stall_cycles = 0;
        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // bad RIFF on the first byte, then on the last tag byte
        wav_bytes = '{8'h00};
        send_wav();
        wav_bytes.delete();
        put_tag(RIFF_TAG);
        wav_bytes[3] = 8'hFF;
        send_wav();
        // bad WAVE on its last byte behind a maximal length
        wav_bytes.delete();
        put_tag(RIFF_TAG);
        put_le(32'hFFFF_FFFF, 4);
        put_tag(WAVE_TAG);
        wav_bytes[11] = 8'h00;
        send_wav();
        // zero RIFF length: end of file straight after the WAVE tag
        wav_bytes.delete();
        put_tag(RIFF_TAG);
        put_le(32'h0, 4);
        put_tag(WAVE_TAG);
        send_wav();

        files = 0;
        holds = 0;
        next_hold = 400;
        while (byte_beats < ITEMS) begin
            if (files < SC_COUNT) begin
                sc = scen_t'(files);
            end else begin
                r = $urandom_range(0, 18);
                sc = (r < 10) ? SC_GOOD : scen_t'(r - 9);
            end
            if (holds < 2 && parsed_beats >= next_hold) begin
                // hold the sink off while bytes keep coming without gaps
                hold_req = 1'b1;
                burst_left = 400;
                holds++;
                next_hold += 600;
            end
            if (sc == SC_NOISE) begin
                send_noise();
            end else begin
                build_wav(sc);
                send_wav();
            end
            files++;
        end
        s_tvalid <= 1'b0;

        while (sb.due() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d files in %0d byte beats, %0d of them reaching a live parse.",
                 files + 4, byte_beats, parsed_beats);
        $display("Results checked: %0d format, %0d sample pairs, %0d errors, %0d end of file.",
                 sb.seen[KIND_FORMAT], sb.seen[KIND_SAMPLE], sb.seen[KIND_ERROR],
                 sb.seen[KIND_EOF]);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/wpp_pkg.sv
sv/wpp_in_stage.sv
sv/wpp_parser.sv
sv/wpp_out_stage.sv
sv/wave_pcm_stream_parser_top.sv
sv/wpp_checker.sv
tb/wave_pcm_stream_parser_top_test.sv
